### src/shadow_fit_texel_snap_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef SHADOW_FIT_TEXEL_SNAP_DEFINES_SVH
`define SHADOW_FIT_TEXEL_SNAP_DEFINES_SVH

// Same-cycle implication.
`define SFTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sfts_pkg.sv
`timescale 1ns / 1ps
package sfts_pkg;

  localparam logic [6:0]         STEPS_DEFAULT = 7'd8;
  localparam logic signed [63:0] ONE_Q58       = 64'sd288230376151711744;
  localparam logic signed [63:0] ORTHO_TOL     = 64'sd288230376151712;
  localparam logic [30:0]        SLACK_Q30     = 31'd1084479242;

  typedef enum logic {
    CFG_EXTENT_STEPS = 1'b0,
    CFG_MAP_TEXELS   = 1'b1
  } cfg_idx_t;

  typedef logic [30:1][30:0] root_tab_t;

  typedef struct packed {
    logic [1:0][2:0][31:0] row;
    logic [2:0][31:0]      pos;
    logic [1:0][31:0]      width;
    logic                  ok;
    logic [1:0][31:0]      qw;
    logic [1:0][31:0]      dmag;
  } item_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) begin
        b = b >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-j) in Q.30 by chained floored square roots from 2.0
  function automatic root_tab_t root_table();
    root_tab_t   tab;
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int j = 1; j <= 30; j++) begin
      root = isqrt64(root << 30);
      tab[j] = root[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = root_table();

  function automatic logic signed [63:0] smul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return a * b;
  endfunction

  function automatic logic [63:0] umul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

endpackage

### src/sfts_check.sv
`timescale 1ns / 1ps
module sfts_check import sfts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item
);

  localparam int CLAT = 3;

  logic [CLAT-1:0]  v;
  item_t            it [CLAT];
  logic [8:0][61:0] pr;
  logic [2:0][63:0] dsum;

  function automatic logic in_tol(input logic signed [63:0] x);
    return !(x > ORTHO_TOL || x < -ORTHO_TOL);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[CLAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    item_t nx;
    if (en) begin
      it[0] <= in_item;
      for (int c = 0; c < 3; c++) begin
        pr[c]     <= 62'(smul32($signed(in_item.row[0][c]),
                                $signed(in_item.row[0][c])) >>> 2);
        pr[3 + c] <= 62'(smul32($signed(in_item.row[1][c]),
                                $signed(in_item.row[1][c])) >>> 2);
        pr[6 + c] <= 62'(smul32($signed(in_item.row[0][c]),
                                $signed(in_item.row[1][c])) >>> 2);
      end
      it[1] <= it[0];
      dsum[0] <= 64'($signed(pr[0])) + 64'($signed(pr[1])) + 64'($signed(pr[2])) - ONE_Q58;
      dsum[1] <= 64'($signed(pr[3])) + 64'($signed(pr[4])) + 64'($signed(pr[5])) - ONE_Q58;
      dsum[2] <= 64'($signed(pr[6])) + 64'($signed(pr[7])) + 64'($signed(pr[8]));
      nx    = it[1];
      nx.ok = it[1].ok && in_tol(dsum[0]) && in_tol(dsum[1]) && in_tol(dsum[2]);
      it[2] <= nx;
    end
  end

  assign out_valid = v[CLAT-1];
  assign out_item  = it[CLAT-1];

endmodule

### src/sfts_quant.sv
`timescale 1ns / 1ps
module sfts_quant import sfts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [6:0] steps,
  input  logic       in_valid,
  input  item_t      in_item,
  output logic       out_valid,
  output item_t      out_item
);

  // stage map: 0 encode, 1 normalize, 2..31 log squaring, 32..33 octave split,
  // 34..63 exp digits, 64 slack, 65 scale, 66 compare
  localparam int QLAT   = 67;
  localparam int S_LOG  = 2;
  localparam int S_T1   = 32;
  localparam int S_T2   = 33;
  localparam int S_EXP  = 34;
  localparam int S_SLK  = 64;
  localparam int S_SCL  = 65;

  typedef struct packed {
    logic [4:0]        p;
    logic [30:0]       m;
    logic [29:0]       frac;
    logic signed [5:0] ipart;
    logic [7:0]        t;
    logic signed [5:0] n;
    logic [7:0]        rem;
    logic [30:0]       mant;
    logic [31:0]       m2;
    logic [31:0]       q;
  } qlane_t;

  logic [QLAT-1:0] v;
  item_t           it [QLAT];
  qlane_t          st [2][QLAT-1];

  function automatic qlane_t q_enc(input logic [31:0] w);
    qlane_t x;
    x   = '0;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) begin
        x.p = 5'(i);
      end
    end
    return x;
  endfunction

  function automatic qlane_t q_norm(input qlane_t xi, input logic [31:0] w);
    qlane_t     x;
    logic [4:0] sh;
    x  = xi;
    sh = 5'd30 - xi.p;
    if (xi.p == 5'd31) begin
      x.m = w[31:1];
    end else begin
      x.m = 31'(w << sh);
    end
    x.ipart = $signed({1'b0, xi.p}) - 6'sd16;
    x.frac  = '0;
    return x;
  endfunction

  function automatic qlane_t q_log(input qlane_t xi);
    qlane_t      x;
    logic [63:0] sq;
    logic [31:0] m2;
    x  = xi;
    sq = umul32({1'b0, xi.m}, {1'b0, xi.m});
    m2 = sq[61:30];
    if (m2[31]) begin
      x.m    = m2[31:1];
      x.frac = {xi.frac[28:0], 1'b1};
    end else begin
      x.m    = m2[30:0];
      x.frac = {xi.frac[28:0], 1'b0};
    end
    return x;
  endfunction

  function automatic qlane_t q_t1(input qlane_t xi, input logic [6:0] es);
    qlane_t      x;
    logic [36:0] tp;
    logic [37:0] ts;
    x   = xi;
    tp  = xi.frac * es;
    ts  = {1'b0, tp} + 38'h3FFF_FFFF;
    x.t = ts[37:30];
    return x;
  endfunction

  function automatic qlane_t q_t2(input qlane_t xi, input logic [6:0] es);
    qlane_t x;
    logic   wrap;
    x      = xi;
    wrap   = (xi.t == {1'b0, es});
    x.n    = xi.ipart + $signed({5'b0, wrap});
    x.rem  = wrap ? 8'd0 : xi.t;
    x.mant = 31'h4000_0000;
    return x;
  endfunction

  function automatic qlane_t q_exp(input qlane_t xi, input logic [4:0] j,
                                   input logic [6:0] es);
    qlane_t      x;
    logic [7:0]  r2;
    logic [63:0] pm;
    x  = xi;
    r2 = {xi.rem[6:0], 1'b0};
    pm = umul32({1'b0, xi.mant}, {1'b0, ROOTS[j]});
    if (r2 >= {1'b0, es}) begin
      x.rem  = r2 - {1'b0, es};
      x.mant = pm[60:30];
    end else begin
      x.rem  = r2;
    end
    return x;
  endfunction

  function automatic qlane_t q_slk(input qlane_t xi);
    qlane_t      x;
    logic [63:0] pm;
    x    = xi;
    pm   = umul32({1'b0, xi.mant}, {1'b0, SLACK_Q30});
    x.m2 = pm[61:30];
    return x;
  endfunction

  function automatic qlane_t q_scl(input qlane_t xi);
    qlane_t      x;
    logic [34:0] res;
    logic [1:0]  up;
    logic [4:0]  dn;
    x  = xi;
    up = 2'(xi.n - 6'sd14);
    dn = 5'(6'sd14 - xi.n);
    if (xi.n >= 6'sd14) begin
      res = 35'(xi.m2) << up;
    end else begin
      res = (35'(xi.m2) + (35'd1 << (dn - 5'd1))) >> dn;
    end
    x.q = (res > 35'h0_FFFF_FFFF) ? '1 : res[31:0];
    return x;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QLAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    item_t nx;
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        st[l][0] <= q_enc(in_item.width[l]);
        st[l][1] <= q_norm(st[l][0], it[0].width[l]);
        for (int s = S_LOG; s < S_T1; s++) begin
          st[l][s] <= q_log(st[l][s-1]);
        end
        st[l][S_T1] <= q_t1(st[l][S_T1-1], steps);
        st[l][S_T2] <= q_t2(st[l][S_T2-1], steps);
        for (int s = S_EXP; s < S_SLK; s++) begin
          st[l][s] <= q_exp(st[l][s-1], 5'(s - S_EXP + 1), steps);
        end
        st[l][S_SLK] <= q_slk(st[l][S_SLK-1]);
        st[l][S_SCL] <= q_scl(st[l][S_SCL-1]);
      end
      it[0] <= in_item;
      for (int s = 1; s < QLAT - 1; s++) begin
        it[s] <= it[s-1];
      end
      nx       = it[QLAT-2];
      nx.qw[0] = st[0][S_SCL].q;
      nx.qw[1] = st[1][S_SCL].q;
      nx.ok    = it[QLAT-2].ok && (st[0][S_SCL].q >= it[QLAT-2].width[0])
                 && (st[1][S_SCL].q >= it[QLAT-2].width[1]);
      it[QLAT-1] <= nx;
    end
  end

  assign out_valid = v[QLAT-1];
  assign out_item  = it[QLAT-1];

endmodule

### src/sfts_offset.sv
`timescale 1ns / 1ps
module sfts_offset import sfts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [14:0] map,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        out_valid,
  output item_t       out_item
);

  // stage map: 0 products, 1 projection, 2 times map, 3 magnitude,
  // 4..54 modulo by width, 55 floor fix, 56..87 ceil divide by map, 88 finish
  localparam int OLAT  = 89;
  localparam int S_MOD = 4;
  localparam int S_FIX = 55;
  localparam int S_DIV = 56;
  localparam int S_END = 88;

  typedef struct packed {
    logic [2:0][41:0] pr;
    logic [43:0]      p;
    logic [59:0]      pm;
    logic             neg;
    logic             lonz;
    logic [50:0]      u;
    logic [31:0]      rem;
    logic [31:0]      a;
    logic [31:0]      quo;
    logic [14:0]      crem;
  } olane_t;

  logic [OLAT-1:0] v;
  item_t           it [OLAT];
  olane_t          st [2][OLAT-1];

  function automatic olane_t o_prod(input item_t x, input int l);
    olane_t o;
    o = '0;
    for (int c = 0; c < 3; c++) begin
      o.pr[c] = 42'(smul32($signed(x.pos[c]), $signed(x.row[l][c])) >>> 22);
    end
    return o;
  endfunction

  function automatic olane_t o_sum(input olane_t xi);
    olane_t o;
    o   = xi;
    o.p = 44'($signed(xi.pr[0])) + 44'($signed(xi.pr[1])) + 44'($signed(xi.pr[2]));
    return o;
  endfunction

  function automatic olane_t o_pm(input olane_t xi, input logic [14:0] mp);
    olane_t             o;
    logic signed [59:0] t;
    o    = xi;
    t    = $signed(xi.p) * $signed({1'b0, mp});
    o.pm = t;
    return o;
  endfunction

  function automatic olane_t o_abs(input olane_t xi);
    olane_t             o;
    logic signed [59:0] vsh;
    logic [59:0]        mag;
    o      = xi;
    vsh    = $signed(xi.pm) >>> 8;
    o.neg  = xi.pm[59];
    o.lonz = |xi.pm[7:0];
    mag    = o.neg ? 60'(-vsh) : 60'(vsh);
    o.u    = mag[50:0];
    o.rem  = '0;
    return o;
  endfunction

  function automatic olane_t o_mod(input olane_t xi, input logic [31:0] q);
    olane_t      o;
    logic [32:0] r2;
    o  = xi;
    r2 = {xi.rem, xi.u[50]};
    if (r2 >= {1'b0, q}) begin
      o.rem = 32'(r2 - {1'b0, q});
    end else begin
      o.rem = r2[31:0];
    end
    o.u = xi.u << 1;
    return o;
  endfunction

  function automatic olane_t o_fix(input olane_t xi, input logic [31:0] q);
    olane_t      o;
    logic [31:0] m;
    o      = xi;
    m      = (xi.neg && xi.rem != 0) ? q - xi.rem : xi.rem;
    o.a    = m + 32'(xi.lonz);
    o.quo  = '0;
    o.crem = '0;
    return o;
  endfunction

  function automatic olane_t o_div(input olane_t xi, input logic [14:0] mp);
    olane_t      o;
    logic [15:0] r2;
    logic        ge;
    o      = xi;
    r2     = {xi.crem, xi.a[31]};
    ge     = (r2 >= {1'b0, mp});
    o.crem = ge ? 15'(r2 - {1'b0, mp}) : r2[14:0];
    o.quo  = {xi.quo[30:0], ge};
    o.a    = xi.a << 1;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[OLAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    item_t nx;
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        st[l][0] <= o_prod(in_item, l);
        st[l][1] <= o_sum(st[l][0]);
        st[l][2] <= o_pm(st[l][1], map);
        st[l][3] <= o_abs(st[l][2]);
        for (int s = S_MOD; s < S_FIX; s++) begin
          st[l][s] <= o_mod(st[l][s-1], it[s-1].qw[l]);
        end
        st[l][S_FIX] <= o_fix(st[l][S_FIX-1], it[S_FIX-1].qw[l]);
        for (int s = S_DIV; s < S_END; s++) begin
          st[l][s] <= o_div(st[l][s-1], map);
        end
      end
      it[0] <= in_item;
      for (int s = 1; s < OLAT - 1; s++) begin
        it[s] <= it[s-1];
      end
      nx = it[OLAT-2];
      for (int l = 0; l < 2; l++) begin
        nx.dmag[l] = st[l][S_END-1].quo + 32'(st[l][S_END-1].crem != 15'd0);
      end
      nx.ok = it[OLAT-2].ok && (map != 15'd0);
      it[OLAT-1] <= nx;
    end
  end

  assign out_valid = v[OLAT-1];
  assign out_item  = it[OLAT-1];

endmodule

### src/sfts_apply.sv
`timescale 1ns / 1ps
module sfts_apply import sfts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item,
  output logic  applied
);

  localparam int ALAT = 3;

  logic [ALAT-1:0]       v;
  item_t                 it [ALAT-1];
  logic [1:0][2:0][63:0] prod;
  logic [1:0][2:0]       neg0;
  logic [1:0][2:0][35:0] term;

  function automatic logic [31:0] mag32(input logic [31:0] r);
    return r[31] ? 32'(-$signed(r)) : r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] x);
    if (x > 38'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (x < -38'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ALAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] rnd;
    logic [33:0] mg;
    item_t       nx;
    if (en) begin
      it[0] <= in_item;
      for (int l = 0; l < 2; l++) begin
        for (int c = 0; c < 3; c++) begin
          prod[l][c] <= umul32(mag32(in_item.row[l][c]), in_item.dmag[l]);
          neg0[l][c] <= in_item.row[l][c][31] != (in_item.dmag[l] != 32'd0);
        end
      end
      it[1] <= it[0];
      for (int l = 0; l < 2; l++) begin
        for (int c = 0; c < 3; c++) begin
          rnd = prod[l][c] + 64'h2000_0000;
          mg  = rnd[63:30];
          term[l][c] <= neg0[l][c] ? 36'(-$signed({1'b0, mg})) : 36'(mg);
        end
      end
      nx = it[1];
      if (it[1].ok) begin
        for (int c = 0; c < 3; c++) begin
          nx.pos[c] = sat32(38'($signed(it[1].pos[c])) + 38'($signed(term[0][c]))
                            + 38'($signed(term[1][c])));
        end
        nx.width = it[1].qw;
      end
      out_item <= nx;
      applied  <= it[1].ok;
    end
  end

  assign out_valid = v[ALAT-1];

endmodule

### src/shadow_fit_texel_snap.sv
// Channel   Dir  Width      Contents
// s_axis    in   352 + 1    one light camera fit request
// m_axis    out  160 + 1    snapped centre and widths
// cfg       in   1 + 15     extent_steps (index 0), map_texels (index 1)
//
// Pipeline order: input register, check, quantize, offset, apply.
// One transaction per cycle sustained while the output is not stalled; the long dividers and the log/exp
// chains are fully pipelined, one step per stage.
// Synchronous reset clears all valid bits and loads extent_steps 8, map_texels 0.
// When the output register holds and m_axis_tready is low, every stage holds.
`timescale 1ns / 1ps
`include "shadow_fit_texel_snap_defines.svh"
module shadow_fit_texel_snap import sfts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [14:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, centre_x, centre_y, centre_z,
  // width_along_row0, width_along_row1
  input  logic [351:0] s_axis_tdata,
  // is_ortho
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_centre_x, new_centre_y, new_centre_z, new_width0, new_width1
  output logic [159:0] m_axis_tdata,
  // applied
  output logic [0:0]   m_axis_tuser
);

  logic [6:0]  extent_steps;
  logic [14:0] map_texels;
  logic [6:0]  steps_eff;
  logic        en;
  logic        v_in;
  item_t       item_d;
  item_t       item_in;
  logic        v_c;
  item_t       item_c;
  logic        v_q;
  item_t       item_q;
  logic        v_o;
  item_t       item_o;
  item_t       item_out;
  logic        applied;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_steps <= STEPS_DEFAULT;
      map_texels   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXTENT_STEPS: extent_steps <= cfg_data[6:0];
        CFG_MAP_TEXELS:   map_texels   <= cfg_data;
      endcase
    end
  end

  assign steps_eff     = (extent_steps == 7'd0) ? STEPS_DEFAULT : extent_steps;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    item_d = '0;
    for (int l = 0; l < 2; l++) begin
      for (int c = 0; c < 3; c++) begin
        item_d.row[l][c] = s_axis_tdata[(3*l + c)*32 +: 32];
      end
    end
    for (int c = 0; c < 3; c++) begin
      item_d.pos[c] = s_axis_tdata[(6 + c)*32 +: 32];
    end
    item_d.width[0] = s_axis_tdata[319:288];
    item_d.width[1] = s_axis_tdata[351:320];
    item_d.ok       = s_axis_tuser[0] && (item_d.width[0] != 32'd0)
                      && (item_d.width[1] != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else if (en) begin
      v_in <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_in <= item_d;
    end
  end

  sfts_check u_check (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_in), .in_item(item_in),
    .out_valid(v_c), .out_item(item_c)
  );

  sfts_quant u_quant (
    .clk(clk), .rst(rst), .en(en), .steps(steps_eff),
    .in_valid(v_c), .in_item(item_c),
    .out_valid(v_q), .out_item(item_q)
  );

  sfts_offset u_offset (
    .clk(clk), .rst(rst), .en(en), .map(map_texels),
    .in_valid(v_q), .in_item(item_q),
    .out_valid(v_o), .out_item(item_o)
  );

  sfts_apply u_apply (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_o), .in_item(item_o),
    .out_valid(m_axis_tvalid), .out_item(item_out), .applied(applied)
  );

  assign m_axis_tdata = {item_out.width[1], item_out.width[0],
                         item_out.pos[2], item_out.pos[1], item_out.pos[0]};
  assign m_axis_tuser = applied;

  `SFTS_ASSERT_NOW(a_applied_map, clk, rst, m_axis_tvalid && m_axis_tuser[0], map_texels != 15'd0, "snapped result with map size zero")
  `SFTS_ASSERT_NOW(a_applied_width, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[127:96] != 32'd0 && m_axis_tdata[159:128] != 32'd0, "snapped result with zero width")
  `SFTS_ASSERT_NEXT(a_accept_lands, clk, rst, s_axis_tvalid && s_axis_tready, v_in, "accepted transaction not captured")
  `SFTS_ASSERT_NOW(a_stall_full, clk, rst, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

endmodule

### dv/shadow_fit_texel_snap_check.sv
`timescale 1ns / 1ps
module shadow_fit_texel_snap_check import sfts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [14:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [351:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [159:0] m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           fails,
  output int           pending
);

  typedef struct {
    logic [31:0] cx, cy, cz;
    logic [31:0] w0, w1;
    logic        applied;
  } fit_t;

  fit_t                snap_queue[$];
  logic [6:0]          steps_reg;
  logic [14:0]         map_reg;
  longint unsigned     roots[1:30];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint dot58(longint a[3], longint b[3]);
    return ((a[0] * b[0]) >>> 2) + ((a[1] * b[1]) >>> 2) + ((a[2] * b[2]) >>> 2);
  endfunction

  function automatic longint log2_fix(logic [31:0] raw);
    int              p;
    longint unsigned m;
    longint          frac;
    p = 31;
    frac = 0;
    while (p > 0 && raw[p] == 1'b0) p--;
    if (p <= 30) m = {32'd0, raw} << (30 - p);
    else m = {32'd0, raw} >> 1;
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'sd1 << (30 - i));
      end
    end
    return longint'(p - 16) * (64'sd1 << 30) + frac;
  endfunction

  function automatic logic [31:0] quant_width(logic [31:0] e, longint st);
    longint          x, k, n, r;
    longint unsigned f, mant, m2, res;
    int              s;
    x = log2_fix(e);
    k = -((-(x * st)) >>> 30);
    n = fdiv(k, st);
    r = k - n * st;
    f = (r << 30) / st;
    mant = 64'd1 << 30;
    for (int j = 1; j <= 30; j++) begin
      if (f[30 - j]) mant = (mant * roots[j]) >> 30;
    end
    m2 = (mant * longint'(SLACK_Q30)) >> 30;
    if (n >= 14) begin
      res = m2 << (n - 14);
    end else begin
      s = int'(14 - n);
      res = (m2 + (64'd1 << (s - 1))) >> s;
    end
    return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
  endfunction

  function automatic longint grid_offset(longint pos[3], longint row[3], logic [31:0] q,
                                         longint mp);
    longint p, pm, gsize, c;
    p = ((pos[0] * row[0]) >>> 22) + ((pos[1] * row[1]) >>> 22) +
        ((pos[2] * row[2]) >>> 22);
    pm = p * mp;
    gsize = longint'({32'd0, q}) * 256;
    c = fdiv(pm, gsize);
    return fdiv(c * gsize - pm, mp * 256);
  endfunction

  function automatic longint row_term(longint r, longint d);
    longint unsigned ur, ud, m;
    ur = (r < 0) ? -r : r;
    ud = (d < 0) ? -d : d;
    m = (ur * ud + (64'd1 << 29)) >> 30;
    return ((r < 0) != (d < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic fit_t snap_fit(logic [351:0] d, logic ortho);
    fit_t        o;
    longint      r0[3], r1[3], pos[3];
    longint      st, mp, a, b, c, d0, d1, v;
    logic [31:0] e0, e1, q0, q1;
    for (int i = 0; i < 3; i++) begin
      r0[i]  = longint'($signed(d[32*i +: 32]));
      r1[i]  = longint'($signed(d[32*(3+i) +: 32]));
      pos[i] = longint'($signed(d[32*(6+i) +: 32]));
    end
    e0 = d[288 +: 32];
    e1 = d[320 +: 32];
    o.cx = d[192 +: 32];
    o.cy = d[224 +: 32];
    o.cz = d[256 +: 32];
    o.w0 = e0;
    o.w1 = e1;
    o.applied = 1'b0;
    st = (steps_reg == 0) ? 8 : longint'(steps_reg);
    mp = longint'(map_reg);
    if (!ortho || e0 == 0 || e1 == 0) return o;
    a = dot58(r0, r0) - ONE_Q58;
    b = dot58(r1, r1) - ONE_Q58;
    c = dot58(r0, r1);
    if (a > ORTHO_TOL || a < -ORTHO_TOL || b > ORTHO_TOL || b < -ORTHO_TOL ||
        c > ORTHO_TOL || c < -ORTHO_TOL) return o;
    q0 = quant_width(e0, st);
    q1 = quant_width(e1, st);
    if (q0 < e0 || q1 < e1 || mp == 0) return o;
    d0 = grid_offset(pos, r0, q0, mp);
    d1 = grid_offset(pos, r1, q1, mp);
    for (int i = 0; i < 3; i++) begin
      v = pos[i] + row_term(r0[i], d0) + row_term(r1[i], d1);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (i == 0) o.cx = v[31:0];
      else if (i == 1) o.cy = v[31:0];
      else o.cz = v[31:0];
    end
    o.w0 = q0;
    o.w1 = q1;
    o.applied = 1'b1;
    return o;
  endfunction

  initial begin
    longint unsigned rt;
    rt = 64'd1 << 31;
    for (int j = 1; j <= 30; j++) begin
      rt = int_sqrt(rt << 30);
      roots[j] = rt;
    end
  end

  assign pending = snap_queue.size();

  always @(posedge clk) begin
    fit_t w;
    if (rst) begin
      steps_reg <= STEPS_DEFAULT;
      map_reg   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_EXTENT_STEPS) steps_reg <= cfg_data[6:0];
        else map_reg <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) snap_queue.push_back(snap_fit(s_axis_tdata,
                                                                          s_axis_tuser[0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (snap_queue.size() == 0) begin
          $error("result transaction with nothing predicted");
          fails++;
        end else begin
          w = snap_queue.pop_front();
          if (m_axis_tdata[31:0] !== w.cx) begin
            $error("new_centre_x exp %h got %h", w.cx, m_axis_tdata[31:0]); fails++;
          end
          if (m_axis_tdata[63:32] !== w.cy) begin
            $error("new_centre_y exp %h got %h", w.cy, m_axis_tdata[63:32]); fails++;
          end
          if (m_axis_tdata[95:64] !== w.cz) begin
            $error("new_centre_z exp %h got %h", w.cz, m_axis_tdata[95:64]); fails++;
          end
          if (m_axis_tdata[127:96] !== w.w0) begin
            $error("new_width0 exp %h got %h", w.w0, m_axis_tdata[127:96]); fails++;
          end
          if (m_axis_tdata[159:128] !== w.w1) begin
            $error("new_width1 exp %h got %h", w.w1, m_axis_tdata[159:128]); fails++;
          end
          if (m_axis_tuser[0] !== w.applied) begin
            $error("applied exp %b got %b", w.applied, m_axis_tuser[0]); fails++;
          end
        end
      end
    end
  end

endmodule

### dv/tb_shadow_fit_texel_snap.sv
`timescale 1ns / 1ps
module tb_shadow_fit_texel_snap;
  import sfts_pkg::*;

  localparam int LATENCY = 163;
  localparam int STALL_LIMIT = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [14:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           fails, pending;
  int           quiet_cycles = 0;
  bit           no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shadow_fit_texel_snap dut (.*);

  shadow_fit_texel_snap_check checker_i (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fails, .pending
  );

  always @(negedge clk) begin
    if (!rst) m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_shadow_fit_texel_snap: done, errors");
      $finish;
    end
  end

  task automatic send_cam(input bit ortho, input logic [31:0] f[11]);
    while (!no_gaps && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 11; i++) s_axis_tdata[32*i +: 32] = f[i];
    s_axis_tuser[0] = ortho;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [14:0] val);
    repeat (LATENCY + 10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] q30(real x);
    return $rtoi(x * 1073741824.0);
  endfunction

  function automatic logic [31:0] rand_width();
    logic [31:0] w;
    int          sh;
    sh = $urandom_range(0, 31);
    w = $urandom() >> sh;
    if (w == 0) w = 1;
    return w;
  endfunction

  // camera: rows orthonormal from two angles unless tweak; random centre, widths
  task automatic send_good(input bit tweak);
    logic [31:0] f[11];
    real         t, p;
    t = $urandom_range(0, 62831) / 10000.0;
    p = $urandom_range(0, 31415) / 10000.0 - 1.5707;
    f[0] = q30($cos(t) * $cos(p));
    f[1] = q30($sin(t) * $cos(p));
    f[2] = q30($sin(p));
    f[3] = q30(-$sin(t));
    f[4] = q30($cos(t));
    f[5] = 32'd0;
    if (tweak) f[$urandom_range(0, 5)] += $urandom_range(0, 4000000) - 2000000;
    for (int i = 6; i < 9; i++) begin
      case ($urandom_range(0, 3))
        0: f[i] = $urandom();
        1: f[i] = $urandom() >> $urandom_range(8, 31);
        2: f[i] = -($urandom() >> $urandom_range(8, 31));
        default: f[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
    end
    f[9] = rand_width();
    f[10] = rand_width();
    send_cam(1'b1, f);
  endtask

  task automatic send_noise();
    logic [31:0] f[11];
    for (int i = 0; i < 11; i++) f[i] = $urandom();
    send_cam($urandom_range(0, 1), f);
  endtask

  task automatic directed();
    logic [31:0] f[11];
    logic [31:0] extremes[4] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000};
    logic [31:0] cents[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    for (int i = 0; i < 16; i++) begin
      f = '{default: 32'd0};
      // axis-aligned rows, sign flips
      f[i % 3] = (i & 4) ? -32'sd1073741824 : 32'sd1073741824;
      f[3 + ((i + 1) % 3)] = (i & 8) ? -32'sd1073741824 : 32'sd1073741824;
      f[6] = cents[i % 4];
      f[7] = cents[(i + 1) % 4];
      f[8] = cents[(i + 2) % 4];
      f[9] = extremes[i % 4];
      f[10] = extremes[(i / 4) % 4];
      send_cam(1'b1, f);
    end
    f[9] = 32'd0;
    send_cam(1'b1, f);            // zero width
    f[9] = 32'h0001_0000;
    f[10] = 32'd0;
    send_cam(1'b1, f);
    f[10] = 32'h0001_0000;
    send_cam(1'b0, f);            // not orthographic
    f[3] = f[0];
    f[4] = f[1];
    f[5] = f[2];
    send_cam(1'b1, f);            // parallel rows
    f[0] = 32'h7FFF_FFFF;
    send_cam(1'b1, f);            // row far from unit length
    send_good(1'b0);
    send_good(1'b1);
  endtask

  initial begin
    logic [6:0]  steps_set[7] = '{7'd8, 7'd8, 7'd1, 7'd64, 7'd0, 7'd127, 7'd13};
    logic [14:0] map_set[7] = '{15'd0, 15'd1024, 15'd16384, 15'd1, 15'd32767, 15'd3, 15'd777};
    repeat (6) @(negedge clk);
    rst = 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(CFG_EXTENT_STEPS, {8'd0, steps_set[ph]});
        write_reg(CFG_MAP_TEXELS, map_set[ph]);
      end
      if (ph == 1 || ph == 4) directed();
      for (int n = 0; n < 115; n++) begin
        no_gaps = (ph == 3);
        if ($urandom_range(0, 99) < 75) send_good($urandom_range(0, 9) == 0);
        else send_noise();
      end
    end
    no_gaps = 1'b0;
    drain();
    repeat (LATENCY + 40) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_shadow_fit_texel_snap: done, clean");
    end else begin
      $display("tb_shadow_fit_texel_snap: done, errors");
    end
    $finish;
  end

endmodule
